[rtl/core/cbfh_pkg.sv]
// Shared types and constants for the steering button frame hold decoder.
// Holds the button pattern table, command codes and register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cbfh_pkg;

  localparam int PATTERN_COUNT = 9;

  // Command codes on the potentiometer side
  localparam logic [1:0] CMD_NONE    = 2'd0;
  localparam logic [1:0] CMD_SET     = 2'd1;
  localparam logic [1:0] CMD_DISABLE = 2'd2;

  // Input kinds
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_MATCH_ID = 2'd0;
  localparam logic [1:0] CFG_HOLD     = 2'd1;
  localparam logic [1:0] CFG_SCAN     = 2'd2;

  localparam logic [10:0] MATCH_ID_RESET = 11'h175;
  localparam logic [15:0] HOLD_RESET     = 16'd150;
  localparam logic [7:0]  SCAN_RESET     = 8'd5;

  // Payload bytes 5, 6, 7 from high to low
  localparam logic [23:0] PATTERNS [PATTERN_COUNT] = '{
    24'h101F00, 24'h300000, 24'h200100,
    24'h400000, 24'h500000, 24'h010001,
    24'h02001F, 24'h040000, 24'h050000
  };
  localparam logic CHANNELS [PATTERN_COUNT] = '{
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1
  };
  localparam logic [1:0] RES_CODES [PATTERN_COUNT] = '{
    2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd3
  };

  typedef struct packed {
    logic       hit;
    logic [3:0] idx;
    logic       chan;
    logic [1:0] rcode;
  } match_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       chan;
    logic [1:0] rcode;
    logic [3:0] idx;
    logic       matched;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/can_button_frame_hold_decoder.sv]
// Top level of the steering button frame hold decoder: control sequencer,
// time keeping, release scan and output register.
// Depends on cbfh_pkg, cbfh_matcher and cbfh_time_mem.
//
//   port group   | dir | contents
//   -------------+-----+------------------------------------------------
//   s_t*         | in  | one request: a CAN frame or a 1 ms tick
//   m_t*         | out | potentiometer commands, tlast on the final one
//   cfg_*        | in  | register writes: match id, hold time, scan period
//
// A frame is taken, then its one result is loaded once the output
// register is free; the next request may be taken while that result waits.
// A tick without a scan leaves the sequencer idle. A scan tick reads the time memory one
// button per cycle (LIVE buttons, LIVE nine by default), then emits one release
// per cycle, or returns to idle if none; stalls on m_tready hold the emit loop.
// rst clears time, scan stamp, active flags, registers and the output.
`timescale 1ns / 1ps
`default_nettype none

module can_button_frame_hold_decoder #(
  parameter int BUTTON_COUNT = 9,
  parameter int TIME_WIDTH   = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // slave side
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // frame_id[10:0], data_byte5, data_byte6, data_byte7
  input  wire logic        s_tuser,   // operation
  // master side
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [15:0] m_tdata,   // pot_command[1:0], pot_channel, resistance_code[1:0],
                                      // button_index[3:0]
  output logic             m_tuser,   // frame_matched
  output logic             m_tlast,   // last
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import cbfh_pkg::*;

  localparam int LIVE = (BUTTON_COUNT < PATTERN_COUNT) ? BUTTON_COUNT : PATTERN_COUNT;
  localparam int IDX_W = (LIVE > 1) ? $clog2(LIVE) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LIVE - 1);

  localparam logic [1:0] ST_IDLE      = 2'd0;
  localparam logic [1:0] ST_FRAME_OUT = 2'd1;
  localparam logic [1:0] ST_SCAN      = 2'd2;
  localparam logic [1:0] ST_EMIT      = 2'd3;

  logic [1:0] state;

  // configuration registers
  logic [10:0] match_id;
  logic [15:0] hold_time;
  logic [7:0]  scan_period;

  // time keeping
  logic [TIME_WIDTH-1:0] now_ms;
  logic [TIME_WIDTH-1:0] now_next;
  logic [TIME_WIDTH-1:0] last_scan;
  logic                  scan_due;

  logic [LIVE-1:0] active;
  logic [LIVE-1:0] rel_mask;

  // scan pipeline
  logic [IDX_W-1:0] scan_idx;
  logic             issue_done;
  logic             rd_q_valid;
  logic [IDX_W-1:0] rd_q_idx;
  logic [TIME_WIDTH-1:0] rd_data;
  logic             aged;

  // frame path
  match_t  match;
  result_t frame_res;
  logic    in_take;
  logic    take_frame;
  logic    take_tick;

  // emit path
  logic [IDX_W-1:0] emit_idx;
  logic [LIVE-1:0]  emit_bit;
  logic             emit_last;
  logic             out_free;
  logic             out_load;
  logic             out_valid;
  result_t          out_res;

  assign s_tready   = (state == ST_IDLE);
  assign in_take    = s_tvalid && s_tready;
  assign take_frame = in_take && (s_tuser == OP_FRAME);
  assign take_tick  = in_take && (s_tuser == OP_TICK);
  assign out_free   = !out_valid || m_tready;
  assign out_load   = out_free && ((state == ST_FRAME_OUT) ||
                                   ((state == ST_EMIT) && (rel_mask != '0)));

  assign now_next = now_ms + TIME_WIDTH'(1);
  assign scan_due = (now_next - last_scan) >= TIME_WIDTH'(scan_period);

  cbfh_matcher #(
    .LIVE(LIVE)
  ) u_matcher (
    .frame_id (s_tdata[10:0]),
    .match_id (match_id),
    .byte5    (s_tdata[18:11]),
    .byte6    (s_tdata[26:19]),
    .byte7    (s_tdata[34:27]),
    .match    (match)
  );

  // Stamp on a matching frame; read one entry per cycle during a scan
  cbfh_time_mem #(
    .DEPTH(LIVE),
    .WIDTH(TIME_WIDTH),
    .AW   (IDX_W)
  ) u_time_mem (
    .clk     (clk),
    .wr_en   (take_frame && match.hit),
    .wr_addr (IDX_W'(match.idx)),
    .wr_data (now_ms),
    .rd_en   ((state == ST_SCAN) && !issue_done),
    .rd_addr (scan_idx),
    .rd_data (rd_data)
  );

  // Released when strictly older than the hold time
  assign aged = (now_ms - rd_data) > TIME_WIDTH'(hold_time);

  // Pick the lowest pending release; last when nothing remains above it
  always_comb begin
    emit_idx = '0;
    for (int i = LIVE - 1; i >= 0; i--) begin
      if (rel_mask[i]) begin
        emit_idx = IDX_W'(i);
      end
    end
    emit_bit  = LIVE'(1) << emit_idx;
    emit_last = ((rel_mask & ~emit_bit) == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_id    <= MATCH_ID_RESET;
      hold_time   <= HOLD_RESET;
      scan_period <= SCAN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MATCH_ID: match_id    <= cfg_data[10:0];
        CFG_HOLD:     hold_time   <= cfg_data;
        CFG_SCAN:     scan_period <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      now_ms     <= '0;
      last_scan  <= '0;
      active     <= '0;
      rel_mask   <= '0;
      scan_idx   <= '0;
      issue_done <= 1'b0;
      rd_q_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // Load a new result, else drop the one the sink just took
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (take_frame) begin
            // Hold the single frame result until the output is free
            if (match.hit) begin
              active[IDX_W'(match.idx)] <= 1'b1;
              frame_res <= '{cmd: CMD_SET, chan: match.chan, rcode: match.rcode,
                             idx: match.idx, matched: 1'b1, last: 1'b1};
            end else begin
              frame_res <= '{cmd: CMD_NONE, chan: 1'b0, rcode: 2'd0,
                             idx: 4'd0, matched: 1'b0, last: 1'b1};
            end
            state <= ST_FRAME_OUT;
          end else if (take_tick) begin
            now_ms <= now_next;
            if (scan_due) begin
              last_scan  <= now_next;
              rel_mask   <= '0;
              scan_idx   <= '0;
              issue_done <= 1'b0;
              rd_q_valid <= 1'b0;
              state      <= ST_SCAN;
            end
          end
        end
        ST_FRAME_OUT: begin
          if (out_free) begin
            out_res   <= frame_res;
            state     <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          // Issue reads, then check each returned entry in the cycle after its read
          if (!issue_done) begin
            rd_q_valid <= 1'b1;
            rd_q_idx   <= scan_idx;
            if (scan_idx == LAST_IDX) begin
              issue_done <= 1'b1;
            end else begin
              scan_idx <= scan_idx + IDX_W'(1);
            end
          end else begin
            rd_q_valid <= 1'b0;
          end
          if (rd_q_valid && active[rd_q_idx] && aged) begin
            rel_mask[rd_q_idx] <= 1'b1;
          end
          if (issue_done && !rd_q_valid) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (rel_mask == '0) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            out_res   <= '{cmd: CMD_DISABLE, chan: CHANNELS[emit_idx], rcode: 2'd0,
                           idx: 4'(emit_idx), matched: 1'b0, last: emit_last};
            rel_mask[emit_idx] <= 1'b0;
            active[emit_idx]   <= 1'b0;
            if (emit_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_res.idx, out_res.rcode, out_res.chan, out_res.cmd};
  assign m_tuser  = out_res.matched;
  assign m_tlast  = out_res.last;

endmodule

`default_nettype wire

[rtl/core/cbfh_matcher.sv]
// Frame matcher: compares identifier and payload bytes 5..7 against the
// button pattern table. Depends on cbfh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbfh_matcher #(
  parameter int LIVE = 9
) (
  input  wire logic [10:0]      frame_id,
  input  wire logic [10:0]      match_id,
  input  wire logic [7:0]       byte5,
  input  wire logic [7:0]       byte6,
  input  wire logic [7:0]       byte7,
  output cbfh_pkg::match_t      match
);
  import cbfh_pkg::*;

  logic [23:0] key;

  assign key = {byte5, byte6, byte7};

  // Scan high to low so the lowest matching pattern wins
  always_comb begin
    match = '0;
    for (int i = LIVE - 1; i >= 0; i--) begin
      if (key == PATTERNS[i]) begin
        match.hit   = 1'b1;
        match.idx   = 4'(i);
        match.chan  = CHANNELS[i];
        match.rcode = RES_CODES[i];
      end
    end
    if (frame_id != match_id) begin
      match = '0;
    end
  end

endmodule

`default_nettype wire

[rtl/core/cbfh_time_mem.sv]
// Activation time store: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cbfh_time_mem #(
  parameter int DEPTH = 9,
  parameter int WIDTH = 32,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for can_button_frame_hold_decoder: directed and random frames and
// ticks, with each potentiometer command checked against an in-bench button/timer model.
// Depends on cbfh_pkg and the decoder RTL; reads no files.

module testbench;
  import cbfh_pkg::*;

  localparam int BUTTONS        = 9;
  localparam int SETTLE_CYCLES  = 30;    // covers a scan that releases nothing
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake on either side
  localparam int PHASE_REQUESTS = 66;

  // Button table, payload bytes 5, 6, 7 from high to low
  localparam logic [23:0] BUTTON_PATTERN [BUTTONS] = '{
    24'h101F00, 24'h300000, 24'h200100,
    24'h400000, 24'h500000, 24'h010001,
    24'h02001F, 24'h040000, 24'h050000
  };
  localparam logic BUTTON_CHANNEL [BUTTONS] = '{
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1
  };
  localparam logic [1:0] BUTTON_RES [BUTTONS] = '{
    2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd3
  };

  typedef struct packed {
    logic        op;
    logic [10:0] frame_id;
    logic [7:0]  byte5;
    logic [7:0]  byte6;
    logic [7:0]  byte7;
  } request_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic [39:0] s_tdata   = '0;
  logic        s_tuser   = 1'b0;
  logic        m_tready  = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [15:0] m_tdata;
  wire         m_tuser;
  wire         m_tlast;

  // Shadow copy of the registers and the button/timer state
  logic [10:0] cur_match_id;
  logic [15:0] cur_hold_ms;
  logic [7:0]  cur_scan_ms;
  logic [31:0] now_ms;
  logic [31:0] last_scan_ms;
  logic        held      [BUTTONS];
  logic [31:0] pressed_at[BUTTONS];

  request_t pending_requests[$];
  result_t  expected_commands[$];
  request_t current_request;
  result_t  oldest_command;
  int       failures     = 0;
  int       quiet_cycles = 0;
  bit       no_idle      = 1'b0;

  can_button_frame_hold_decoder uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Work out the commands one accepted request causes and queue them in order.
  task automatic decode_request(input request_t r);
    result_t    cmd;
    logic       found;
    logic       drop[BUTTONS];
    int         to_release;
    int         emitted;
    found      = 1'b0;
    to_release = 0;
    emitted    = 0;
    cmd        = '0;
    if (r.op == OP_FRAME) begin
      // A frame always answers once: a set on the first matching button, else nothing
      cmd.last = 1'b1;
      if (r.frame_id == cur_match_id) begin
        for (int i = 0; i < BUTTONS; i++) begin
          if (!found && {r.byte5, r.byte6, r.byte7} == BUTTON_PATTERN[i]) begin
            found         = 1'b1;
            held[i]       = 1'b1;
            pressed_at[i] = now_ms;
            cmd.cmd       = CMD_SET;
            cmd.chan      = BUTTON_CHANNEL[i];
            cmd.rcode     = BUTTON_RES[i];
            cmd.idx       = 4'(i);
            cmd.matched   = 1'b1;
          end
        end
      end
      expected_commands.push_back(cmd);
    end else begin
      // Advance time; scan only once the scan period has elapsed
      now_ms = now_ms + 32'd1;
      if (now_ms - last_scan_ms >= {24'd0, cur_scan_ms}) begin
        last_scan_ms = now_ms;
        for (int i = 0; i < BUTTONS; i++) begin
          drop[i] = held[i] && (now_ms - pressed_at[i] > {16'd0, cur_hold_ms});
          if (drop[i]) to_release++;
        end
        // Release in ascending button order; mark the final one
        for (int i = 0; i < BUTTONS; i++) begin
          if (drop[i]) begin
            held[i]       = 1'b0;
            pressed_at[i] = '0;
            emitted++;
            cmd      = '0;
            cmd.cmd  = CMD_DISABLE;
            cmd.chan = BUTTON_CHANNEL[i];
            cmd.idx  = 4'(i);
            cmd.last = (emitted == to_release);
            expected_commands.push_back(cmd);
          end
        end
      end
    end
  endtask

  // Request driver: hold a request until taken, then advance to the next pending one.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        decode_request(current_request);
      end
      if (!s_tvalid || s_tready) begin
        if (pending_requests.size() > 0 && (no_idle || $urandom_range(99) >= 15)) begin
          current_request = pending_requests.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= current_request.op;
          s_tdata  <= {5'd0, current_request.byte7, current_request.byte6,
                       current_request.byte5, current_request.frame_id};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Sink side: stall at random except during the no-idle stretch
  always @(posedge clk) begin
    m_tready <= !rst && (no_idle || $urandom_range(99) >= 15);
  end

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endtask

  // Command monitor: match each accepted command against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_commands.size() == 0) begin
        $error("unexpected command: pot_command %0d button_index %0d",
               m_tdata[1:0], m_tdata[8:5]);
        failures++;
      end else begin
        oldest_command = expected_commands.pop_front();
        compare_field("pot_command", oldest_command.cmd, m_tdata[1:0]);
        compare_field("pot_channel", oldest_command.chan, m_tdata[2]);
        compare_field("resistance_code", oldest_command.rcode, m_tdata[4:3]);
        compare_field("button_index", oldest_command.idx, m_tdata[8:5]);
        compare_field("frame_matched", oldest_command.matched, m_tuser);
        compare_field("last", oldest_command.last, m_tlast);
      end
    end
  end

  // Watchdog: end the run when no handshake happens for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_request(input logic op, input logic [10:0] id, input logic [23:0] payload);
    request_t r;
    r.op       = op;
    r.frame_id = id;
    {r.byte5, r.byte6, r.byte7} = payload;
    pending_requests.push_back(r);
  endtask

  // Ticks and well-formed button frames on the live id, plus some noise frames
  task automatic push_random_request();
    int          pick;
    logic [10:0] id;
    logic [23:0] payload;
    pick    = $urandom_range(99);
    id      = 11'($urandom);
    payload = 24'($urandom);
    if (pick < 45) begin
      push_request(OP_TICK, id, payload);
    end else if (pick < 80) begin
      push_request(OP_FRAME, cur_match_id, BUTTON_PATTERN[$urandom_range(BUTTONS - 1)]);
    end else if (pick < 87) begin
      push_request(OP_FRAME, cur_match_id, payload);
    end else if (pick < 94) begin
      push_request(OP_FRAME, id, BUTTON_PATTERN[$urandom_range(BUTTONS - 1)]);
    end else begin
      push_request(OP_FRAME, id, payload);
    end
  endtask

  // Hold the sender until every queued request is taken and every command has come,
  // then let a scan that releases nothing finish.
  task automatic settle();
    @(negedge clk);
    while (pending_requests.size() != 0 || s_tvalid || expected_commands.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      CFG_MATCH_ID: cur_match_id = value[10:0];
      CFG_HOLD:     cur_hold_ms  = value;
      CFG_SCAN:     cur_scan_ms  = value[7:0];
      default: ;
    endcase
  endtask

  initial begin
    logic [10:0] phase_id  [6];
    logic [15:0] phase_hold[6];
    logic [7:0]  phase_scan[6];

    cur_match_id = MATCH_ID_RESET;
    cur_hold_ms  = HOLD_RESET;
    cur_scan_ms  = SCAN_RESET;
    now_ms       = '0;
    last_scan_ms = '0;
    for (int i = 0; i < BUTTONS; i++) begin
      held[i]       = 1'b0;
      pressed_at[i] = '0;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset register values: press every button, re-press one,
    // wrong id, unmatched payload, field extremes, then ticks through a scan
    // that is too early to release anything.
    for (int i = 0; i < BUTTONS; i++) push_request(OP_FRAME, MATCH_ID_RESET, BUTTON_PATTERN[i]);
    push_request(OP_FRAME, MATCH_ID_RESET, BUTTON_PATTERN[2]);
    push_request(OP_FRAME, 11'h174, BUTTON_PATTERN[0]);
    push_request(OP_FRAME, MATCH_ID_RESET, 24'hFFFFFF);
    push_request(OP_FRAME, 11'h7FF, 24'h000000);
    push_request(OP_FRAME, 11'h000, 24'h101F01);
    repeat (6) push_request(OP_TICK, 11'h000, 24'h000000);
    settle();

    // Zero hold and zero scan period: the next tick releases all nine buttons,
    // then two buttons sharing a channel are both disabled.
    write_reg(CFG_MATCH_ID, 16'd2047);
    write_reg(CFG_HOLD, 16'd0);
    write_reg(CFG_SCAN, 16'd0);
    push_request(OP_FRAME, 11'h7FF, BUTTON_PATTERN[6]);
    push_request(OP_TICK, 11'h7FF, 24'hFFFFFF);
    push_request(OP_FRAME, 11'h7FF, BUTTON_PATTERN[0]);
    push_request(OP_FRAME, 11'h7FF, BUTTON_PATTERN[3]);
    push_request(OP_TICK, 11'h000, 24'h000000);
    push_request(OP_FRAME, MATCH_ID_RESET, BUTTON_PATTERN[0]);
    push_request(OP_TICK, 11'h000, 24'h000000);
    settle();

    // Random phases, each with its own register settings
    phase_id   = '{11'h000, 11'($urandom), MATCH_ID_RESET, 11'h7FF, 11'($urandom), 11'($urandom)};
    phase_hold = '{16'd3, 16'hFFFF, 16'd40, 16'd0, 16'($urandom_range(20)), 16'd8};
    phase_scan = '{8'd1, 8'hFF, 8'd5, 8'd0, 8'($urandom_range(10)), 8'd2};
    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_MATCH_ID, {5'd0, phase_id[p]});
      write_reg(CFG_HOLD, phase_hold[p]);
      write_reg(CFG_SCAN, {8'd0, phase_scan[p]});
      // One long stretch with no idling on either side
      no_idle = (p == 4);
      repeat (PHASE_REQUESTS) push_random_request();
      settle();
    end
    no_idle = 1'b0;

    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
